// ----- design/ple_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 3;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_BACK  = 3'd1,
		REQ_INS_AFTER = 3'd2,
		REQ_DEL_FRONT = 3'd3,
		REQ_DEL_BACK  = 3'd4,
		REQ_DEL_AT    = 3'd5,
		REQ_DUMP      = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_DUMP
	} fsm_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t          kind;
		logic [CNT_W-1:0]  k;
		logic [CNT_W-1:0]  n;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

// ----- design/positional_list_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Every result is registered and appears in the cycle after its request is accepted.
// Edits shift every cell of the chain together: one request per cycle, busy low.
// A dump of n elements gives n beats on consecutive cycles (chain rotates
// once per beat); busy stays high from the accept until the last beat is issued.
// Reset empties the list; results cannot be stalled by the receiver.
module positional_list_engine_top import ple_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [REQ_W-1:0]          req_type,
	input  logic signed [DATA_W-1:0]  item_value,
	input  logic [POS_W-1:0]          position,
	output logic                      done,
	output logic [1:0]                status,
	output logic signed [DATA_W-1:0]  out_value,
	output logic [LEN_W-1:0]          length,
	output logic                      last_of_run
);

	cell_cmd_t         cmd;
	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] res_value;

	ple_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.item_value  (item_value),
		.position    (position),
		.cell_val    (cell_val),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.out_value   (res_value),
		.length      (length),
		.last_of_run (last_of_run)
	);

	assign out_value = res_value;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] prev_v;
		logic [DATA_W-1:0] next_v;

		if (g == 0) begin : g_head
			assign prev_v = '0;
		end else begin : g_mid
			assign prev_v = cell_val[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign next_v = '0;
		end else begin : g_body
			assign next_v = cell_val[g+1];
		end

		ple_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.idx      (IDX_W'(g)),
			.prev_val (prev_v),
			.next_val (next_v),
			.wrap_val (cell_val[0]),
			.val      (cell_val[g])
		);
	end

endmodule

// ----- design/ple_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One slot of the element chain: holds, loads, or takes a neighbor's or the head's value.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] prev_val,
	input  logic [DATA_W-1:0] next_val,
	input  logic [DATA_W-1:0] wrap_val,
	output logic [DATA_W-1:0] val
);

	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] val_d;
	logic [CNT_W:0]    i0;
	logic [CNT_W:0]    i1;
	logic [CNT_W:0]    k;
	logic [CNT_W:0]    n;

	assign i0 = (CNT_W + 1)'(idx);
	assign i1 = i0 + 1'b1;
	assign k  = {1'b0, cmd.k};
	assign n  = {1'b0, cmd.n};

	always_comb begin
		val_d = val_q;
		case (cmd.kind)
			OP_INSERT: begin
				if (i0 == k)
					val_d = cmd.value;
				else if (i0 > k && i0 <= n)
					val_d = prev_val;
			end
			OP_DELETE: begin
				if (i0 >= k && i1 < n)
					val_d = next_val;
			end
			OP_ROTATE: begin
				// rotate the live part of the chain: head goes to the tail slot
				if (i1 < n)
					val_d = next_val;
				else if (i1 == n)
					val_d = wrap_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

// ----- design/ple_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decode, element count, dump sequencing and result registers.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [DATA_W-1:0]        item_value,
	input  logic [POS_W-1:0]         position,
	input  logic [DATA_W-1:0]        cell_val [CAPACITY],
	output cell_cmd_t                cmd,
	output logic                     busy,
	output logic                     done,
	output logic [1:0]               status,
	output logic [DATA_W-1:0]        out_value,
	output logic [LEN_W-1:0]         length,
	output logic                     last_of_run
);

	fsm_t              st_q, st_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  left_q, left_d;
	logic              done_q, done_d;
	status_t           status_q, status_d;
	logic [DATA_W-1:0] value_q, value_d;
	logic [LEN_W-1:0]  length_q;
	logic              last_q, last_d;
	logic              pos_ok;
	logic [CNT_W-1:0]  del_k;
	req_t              req;

	assign req    = req_t'(req_type);
	assign pos_ok = (position != '0) && (CMP_W'(position) <= CMP_W'(count_q));
	assign busy   = (st_q == FSM_DUMP);

	always_comb begin
		st_d      = st_q;
		count_d   = count_q;
		left_d    = left_q;
		done_d    = 1'b0;
		status_d  = ST_OK;
		value_d   = '0;
		last_d    = 1'b1;
		del_k     = '0;
		cmd.kind  = OP_HOLD;
		cmd.k     = '0;
		cmd.n     = count_q;
		cmd.value = item_value;
		case (st_q)
			FSM_IDLE: begin
				if (start) begin
					done_d = 1'b1;
					case (req)
						REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AFTER: begin
							if (CMP_W'(count_q) == CMP_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else if (req == REQ_INS_AFTER && count_q != '0
									&& !pos_ok) begin
								status_d = ST_BADPOS;
							end else begin
								cmd.kind = OP_INSERT;
								if (req == REQ_INS_FRONT)
									cmd.k = '0;
								else if (req == REQ_INS_BACK || count_q == '0)
									cmd.k = count_q;
								else
									cmd.k = CNT_W'(position);
								count_d = count_q + 1'b1;
							end
						end
						REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (req == REQ_DEL_AT && !pos_ok) begin
								status_d = ST_BADPOS;
							end else begin
								if (req == REQ_DEL_FRONT)
									del_k = '0;
								else if (req == REQ_DEL_BACK)
									del_k = count_q - 1'b1;
								else
									del_k = CNT_W'(position) - 1'b1;
								cmd.kind = OP_DELETE;
								cmd.k    = del_k;
								value_d  = cell_val[del_k[IDX_W-1:0]];
								count_d  = count_q - 1'b1;
							end
						end
						REQ_DUMP: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								// first beat goes out now; the rest follow one a cycle
								cmd.kind = OP_ROTATE;
								value_d  = cell_val[0];
								last_d   = (count_q == CNT_W'(1));
								left_d   = count_q - 1'b1;
								if (count_q != CNT_W'(1))
									st_d = FSM_DUMP;
							end
						end
						default: status_d = ST_OK;
					endcase
				end
			end
			FSM_DUMP: begin
				cmd.kind = OP_ROTATE;
				done_d   = 1'b1;
				value_d  = cell_val[0];
				last_d   = (left_q == CNT_W'(1));
				left_d   = left_q - 1'b1;
				if (left_q == CNT_W'(1))
					st_d = FSM_IDLE;
			end
			default: st_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= FSM_IDLE;
			count_q <= '0;
			left_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			left_q  <= left_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		value_q  <= value_d;
		length_q <= LEN_W'(count_d);
		last_q   <= last_d;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_value   = value_q;
	assign length      = length_q;
	assign last_of_run = last_q;

endmodule

// ----- design/ple_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the positional list engine.
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             done,
	input  logic [1:0]       status,
	input  logic [LEN_W-1:0] length,
	input  logic             last_of_run
);

	// every accepted request answers on the next cycle
	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted request gave no beat");

	// a dump in progress gives a beat every cycle
	a_busy_beats: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("dump stalled");

	// errors are always single-beat runs
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> last_of_run)
		else $error("error beat not marked last");

	// more beats pending means no new request can get in
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_of_run |-> busy)
		else $error("open run without busy");

	// dump beats all report the same length
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_of_run |=> done && length == $past(length))
		else $error("length changed within a run");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.length      (length),
	.last_of_run (last_of_run)
);

// ----- tb/sv/tb_positional_list_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine: a directed pass over
// the empty, full, bad-position and single-element cases, then shaped random
// traffic. A queue-based list model predicts every result beat; the monitor
// compares each done beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
	import ple_pkg::*;

	localparam logic [REQ_W-1:0]         REQ_UNUSED = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN    = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX    = 32'sh7fff_ffff;
	localparam int IDLE_PCT   = 13;
	localparam int RAND_ITEMS = 40;
	localparam int PRINT_CAP  = 40;

	typedef struct {
		logic [REQ_W-1:0]         kind;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         pos;
	} list_req_t;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] value;
		logic [LEN_W-1:0]         len;
		logic                     last;
	} result_beat_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] item_value;
	logic [POS_W-1:0]         position;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] out_value;
	logic [LEN_W-1:0]         length;
	logic                     last_of_run;

	list_req_t                pending_reqs[$];
	result_beat_t             expected_beats[$];
	logic signed [DATA_W-1:0] list_model[$];
	list_req_t                next_req;
	result_beat_t             want;
	logic                     took;
	int                       issued;
	int                       gen_len;
	int                       mismatches;

	positional_list_engine_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.item_value (item_value),
		.position   (position),
		.done       (done),
		.status     (status),
		.out_value  (out_value),
		.length     (length),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200us;
		$display("tb_positional_list_engine_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (mismatches < PRINT_CAP)
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	function automatic void push_beat(status_t st, logic signed [DATA_W-1:0] v, logic last);
		result_beat_t b;
		b.status = st;
		b.value  = v;
		b.len    = LEN_W'(list_model.size());
		b.last   = last;
		expected_beats.push_back(b);
	endfunction

	// list behavior: apply one request to the model and queue its result beats
	function automatic void predict_list_op(list_req_t r);
		int n;
		logic signed [DATA_W-1:0] v;
		n = list_model.size();
		case (r.kind)
			REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AFTER: begin
				if (n >= CAPACITY) begin
					push_beat(ST_FULL, '0, 1'b1);
				end else if (r.kind == REQ_INS_FRONT) begin
					list_model.push_front(r.value);
					push_beat(ST_OK, '0, 1'b1);
				end else if (r.kind == REQ_INS_BACK || n == 0) begin
					list_model.push_back(r.value);
					push_beat(ST_OK, '0, 1'b1);
				end else if (r.pos < 1 || r.pos > n) begin
					push_beat(ST_BADPOS, '0, 1'b1);
				end else begin
					list_model.insert(r.pos, r.value);
					push_beat(ST_OK, '0, 1'b1);
				end
			end
			REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
				if (n == 0) begin
					push_beat(ST_EMPTY, '0, 1'b1);
				end else if (r.kind == REQ_DEL_FRONT) begin
					v = list_model.pop_front();
					push_beat(ST_OK, v, 1'b1);
				end else if (r.kind == REQ_DEL_BACK) begin
					v = list_model.pop_back();
					push_beat(ST_OK, v, 1'b1);
				end else if (r.pos < 1 || r.pos > n) begin
					push_beat(ST_BADPOS, '0, 1'b1);
				end else begin
					v = list_model[r.pos - 1];
					list_model.delete(r.pos - 1);
					push_beat(ST_OK, v, 1'b1);
				end
			end
			REQ_DUMP: begin
				if (n == 0)
					push_beat(ST_EMPTY, '0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						push_beat(ST_OK, list_model[i], i == n - 1);
			end
			default: push_beat(ST_OK, '0, 1'b1);
		endcase
	endfunction

	// queue a request; track only the element count so random traffic can be shaped
	task automatic queue_req(input logic [REQ_W-1:0] kind, input logic signed [DATA_W-1:0] v,
			input int pos);
		list_req_t r;
		r.kind  = kind;
		r.value = v;
		r.pos   = POS_W'(pos);
		pending_reqs.push_back(r);
		case (kind)
			REQ_INS_FRONT, REQ_INS_BACK:
				if (gen_len < CAPACITY) gen_len++;
			REQ_INS_AFTER:
				if (gen_len < CAPACITY && (gen_len == 0 || (pos >= 1 && pos <= gen_len)))
					gen_len++;
			REQ_DEL_FRONT, REQ_DEL_BACK:
				if (gen_len > 0) gen_len--;
			REQ_DEL_AT:
				if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
			default: ;
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(19))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// mostly a position that names an element, sometimes anything in range
	function automatic int rand_pos();
		if (gen_len > 0 && $urandom_range(99) < 80)
			return $urandom_range(gen_len, 1);
		return $urandom_range(CAPACITY, 0);
	endfunction

	task automatic queue_random(input bit grow);
		int r;
		r = $urandom_range(99);
		if (r < (grow ? 60 : 30)) begin
			case ($urandom_range(2))
				0:       queue_req(REQ_INS_FRONT, rand_value(), rand_pos());
				1:       queue_req(REQ_INS_BACK, rand_value(), rand_pos());
				default: queue_req(REQ_INS_AFTER, rand_value(), rand_pos());
			endcase
		end else if (r < 92) begin
			case ($urandom_range(2))
				0:       queue_req(REQ_DEL_FRONT, rand_value(), rand_pos());
				1:       queue_req(REQ_DEL_BACK, rand_value(), rand_pos());
				default: queue_req(REQ_DEL_AT, rand_value(), rand_pos());
			endcase
		end else if (r < 99) begin
			queue_req(REQ_DUMP, rand_value(), rand_pos());
		end else begin
			queue_req(REQ_UNUSED, rand_value(), rand_pos());
		end
	endtask

	// driver: present a request at the falling edge, hold it until accepted
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_reqs.size() > 0 &&
					!((issued < 40 || issued >= 75) && $urandom_range(99) < IDLE_PCT)) begin
				next_req = pending_reqs.pop_front();
				req_type   <= next_req.kind;
				item_value <= next_req.value;
				position   <= next_req.pos;
				start      <= 1'b1;
				issued++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check the beat of this edge first, then predict for a new accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", out_value, '0);
				end else begin
					want = expected_beats.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (out_value !== want.value)
						report_mismatch("out_value", out_value, want.value);
					if (length !== want.len)
						report_mismatch("length", length, want.len);
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", last_of_run, want.last);
				end
			end
			if (start && !busy) begin
				predict_list_op('{kind: req_type, value: item_value, pos: position});
			end
			took <= start && !busy;
		end
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = '0;
		item_value = '0;
		position   = '0;
		took       = 1'b0;
		issued     = 0;
		gen_len    = 0;
		mismatches = 0;

		// empty list, insert after into empty, single-element delete back
		queue_req(REQ_DUMP, 0, 0);
		queue_req(REQ_DEL_FRONT, 0, 0);
		queue_req(REQ_DEL_BACK, 0, 0);
		queue_req(REQ_DEL_AT, 0, 5);
		queue_req(REQ_INS_AFTER, 32'sd12345, 7);
		queue_req(REQ_DEL_BACK, 0, 0);
		queue_req(REQ_INS_AFTER, -7, 0);
		// value extremes and positions at both edges
		queue_req(REQ_INS_FRONT, VAL_MIN, 0);
		queue_req(REQ_INS_BACK, VAL_MAX, 0);
		queue_req(REQ_INS_AFTER, -1, 1);
		queue_req(REQ_INS_AFTER, 32'sh5555_aaaa, 0);
		queue_req(REQ_INS_AFTER, 32'sh5555_aaaa, gen_len + 1);
		queue_req(REQ_DEL_AT, 0, 0);
		queue_req(REQ_DEL_AT, 0, CAPACITY);
		queue_req(REQ_INS_AFTER, 32'shaaaa_5555, gen_len);
		queue_req(REQ_DEL_AT, 0, 2);
		queue_req(REQ_DUMP, 0, 0);
		queue_req(REQ_UNUSED, -1, CAPACITY);
		queue_req(REQ_DEL_FRONT, 0, 0);
		queue_req(REQ_DEL_AT, 0, gen_len);

		// fill to capacity with random content, then hit the full cases, dump and delete at both ends
		while (gen_len < CAPACITY)
			queue_req(REQ_INS_AFTER, rand_value(), rand_pos());
		queue_req(REQ_INS_AFTER, rand_value(), CAPACITY);
		queue_req(REQ_INS_FRONT, rand_value(), 0);
		queue_req(REQ_INS_BACK, rand_value(), 0);
		queue_req(REQ_DUMP, 0, 0);
		queue_req(REQ_DEL_AT, 0, CAPACITY);
		queue_req(REQ_DEL_AT, 0, 1);

		// alternate growing and shrinking stretches
		for (int i = 0; i < RAND_ITEMS; i++)
			queue_random(((i / 10) % 2) == 0);
		while (gen_len > 0)
			queue_req(REQ_DEL_AT, 0, rand_pos());
		queue_req(REQ_DUMP, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || start || expected_beats.size() > 0)
			@(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);

		if (mismatches == 0 && expected_beats.size() == 0)
			$display("tb_positional_list_engine_top OK");
		else
			$display("tb_positional_list_engine_top NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
design/ple_pkg.sv
design/ple_cell.sv
design/ple_ctrl.sv
design/positional_list_engine_top.sv
design/ple_checker.sv
tb/sv/tb_positional_list_engine_top.sv
